[rtl/core/spi_mbe_pkg.sv]
`default_nettype none
package spi_mbe_pkg;

	// Register reset value and lower bound of the SCK period
	localparam logic [15:0] PERIOD_RESET = 16'd2;
	localparam logic [15:0] PERIOD_MIN   = 16'd2;

	// Wait counter wide enough for 4 * 65535
	localparam int unsigned TICK_W = 18;

	// Sequencer phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_PRE   = 8'b0000_0010,
		PH_LEAD  = 8'b0000_0100,
		PH_LOAD  = 8'b0000_1000,
		PH_SETUP = 8'b0001_0000,
		PH_HOLD  = 8'b0010_0000,
		PH_TAIL1 = 8'b0100_0000,
		PH_TAIL2 = 8'b1000_0000
	} phase_t;

	// One tick request
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last_byte;
		logic       sdi_level;
	} tick_in_t;

	// One tick result
	typedef struct packed {
		logic       sck_level;
		logic       sdo_level;
		logic       cs_n_level;
		logic       byte_taken;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_last;
		logic       busy_res;
	} tick_out_t;

endpackage
`default_nettype wire

[rtl/core/spi_master_bit_engine_top.sv]
// SPI master bit engine, mode 0, MSB first, 8-bit frames.
// Input channel (in_valid / in_stall / in_data): one request per timing tick,
// carrying the SDI level and an offered transmit byte with its last mark.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// request, giving the pin levels after that tick, whether the offered byte was
// taken, and any byte completed on the final SCK fall.
// Path: input register, then sequencer logic into the result register.
// Throughput: one request per cycle while out_stall is low; the sequencer
// state advances only when the input register hands a request on.
// When the receiver stalls, the result register holds and the input register
// fills, then in_stall rises; no request is lost or repeated.
// cfg_wr_en / cfg_wr_data write the SCK period in ticks (reset 2, values
// below 2 act as 2); write it only while the block is idle.
// Reset: chip select high, SCK and SDO low, sequencer idle, both pipeline
// registers empty.
`default_nettype none
module spi_master_bit_engine_top (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  spi_mbe_pkg::tick_in_t  in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output spi_mbe_pkg::tick_out_t out_data,
	input  wire                    cfg_wr_en,
	input  wire  [15:0]            cfg_wr_data
);

	logic [15:0]            period_q;
	logic                   valid_s1;
	spi_mbe_pkg::tick_in_t  data_s1;
	logic                   valid_s2;
	spi_mbe_pkg::tick_out_t data_s2;
	spi_mbe_pkg::tick_out_t res;
	logic                   adv_s2;
	logic                   adv_s1;
	logic                   fire;

	// Pipeline advance
	always_comb begin
		adv_s2   = !(valid_s2 && out_stall);
		fire     = valid_s1 && adv_s2;
		adv_s1   = !valid_s1 || adv_s2;
		in_stall = !adv_s1;
	end

	// Period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= spi_mbe_pkg::PERIOD_RESET;
		else if (cfg_wr_en)
			period_q <= cfg_wr_data;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv_s1)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid)
			data_s1 <= in_data;
	end

	// Sequencer
	spi_mbe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.tick       (data_s1),
		.bit_period (period_q),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire)
			data_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

[rtl/core/spi_mbe_seq.sv]
`default_nettype none
module spi_mbe_seq (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  spi_mbe_pkg::tick_in_t  tick,
	input  wire  [15:0]            bit_period,
	output spi_mbe_pkg::tick_out_t res
);

	localparam int unsigned TW = spi_mbe_pkg::TICK_W;

	spi_mbe_pkg::phase_t phase_q, phase_d;
	logic [TW-1:0]       tick_q, tick_d;
	logic [2:0]          bit_q, bit_d;
	logic [7:0]          tx_q, tx_d;
	logic [7:0]          rx_q, rx_d;
	logic                final_q, final_d;
	logic                sck_q, sck_d;
	logic                sdo_q, sdo_d;
	logic                cs_q, cs_d;

	logic [15:0]   period;
	logic [TW-1:0] pre_w;
	logic [TW-1:0] half_w;
	logic [TW-1:0] tick_inc;
	logic          pre_done;
	logic          half_done;
	logic          taken;
	logic          rx_done;
	logic [2:0]    bit_nx;

	// Period clamp and wait lengths
	always_comb begin
		period   = (bit_period < spi_mbe_pkg::PERIOD_MIN) ? spi_mbe_pkg::PERIOD_MIN : bit_period;
		pre_w    = {period, 2'b00};
		half_w   = {3'b000, period[15:1]};
		tick_inc = tick_q + 1'b1;
		pre_done  = (tick_inc >= pre_w);
		half_done = (tick_inc >= half_w);
		bit_nx    = bit_q + 1'b1;
	end

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		final_d = final_q;
		sck_d   = sck_q;
		sdo_d   = sdo_q;
		cs_d    = cs_q;
		taken   = 1'b0;
		rx_done = 1'b0;

		case (phase_q)
			spi_mbe_pkg::PH_IDLE: begin
				if (tick.tx_valid) begin
					tick_d  = '0;
					cs_d    = 1'b1;
					phase_d = spi_mbe_pkg::PH_PRE;
				end
			end
			spi_mbe_pkg::PH_PRE: begin
				tick_d = pre_done ? '0 : tick_inc;
				if (pre_done) begin
					cs_d    = 1'b0;
					phase_d = spi_mbe_pkg::PH_LEAD;
				end
			end
			spi_mbe_pkg::PH_LEAD, spi_mbe_pkg::PH_LOAD: begin
				if (phase_q == spi_mbe_pkg::PH_LEAD)
					tick_d = half_done ? '0 : tick_inc;
				if (phase_q == spi_mbe_pkg::PH_LOAD || half_done) begin
					phase_d = spi_mbe_pkg::PH_LOAD;
					if (tick.tx_valid) begin
						taken   = 1'b1;
						tx_d    = tick.tx_byte;
						final_d = tick.last_byte;
						bit_d   = '0;
						tick_d  = '0;
						sdo_d   = tick.tx_byte[7];
						phase_d = spi_mbe_pkg::PH_SETUP;
					end
				end
			end
			spi_mbe_pkg::PH_SETUP: begin
				tick_d = half_done ? '0 : tick_inc;
				if (half_done) begin
					sck_d   = 1'b1;
					rx_d    = {rx_q[6:0], tick.sdi_level};
					phase_d = spi_mbe_pkg::PH_HOLD;
				end
			end
			spi_mbe_pkg::PH_HOLD: begin
				tick_d = half_done ? '0 : tick_inc;
				if (half_done) begin
					sck_d = 1'b0;
					if (bit_q != 3'd7) begin
						bit_d   = bit_nx;
						sdo_d   = tx_q[3'd7 - bit_nx];
						phase_d = spi_mbe_pkg::PH_SETUP;
					end else begin
						rx_done = 1'b1;
						if (final_q) begin
							phase_d = spi_mbe_pkg::PH_TAIL1;
						end else begin
							phase_d = spi_mbe_pkg::PH_LOAD;
							if (tick.tx_valid) begin
								taken   = 1'b1;
								tx_d    = tick.tx_byte;
								final_d = tick.last_byte;
								bit_d   = '0;
								tick_d  = '0;
								sdo_d   = tick.tx_byte[7];
								phase_d = spi_mbe_pkg::PH_SETUP;
							end
						end
					end
				end
			end
			spi_mbe_pkg::PH_TAIL1: begin
				tick_d = half_done ? '0 : tick_inc;
				if (half_done) begin
					sdo_d   = 1'b0;
					phase_d = spi_mbe_pkg::PH_TAIL2;
				end
			end
			spi_mbe_pkg::PH_TAIL2: begin
				tick_d = half_done ? '0 : tick_inc;
				if (half_done) begin
					cs_d    = 1'b1;
					phase_d = spi_mbe_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = spi_mbe_pkg::PH_IDLE;
			end
		endcase
	end

	// Result of this tick: pin levels after the update
	always_comb begin
		res.sck_level  = sck_d;
		res.sdo_level  = sdo_d;
		res.cs_n_level = cs_d;
		res.byte_taken = taken;
		res.rx_valid   = rx_done;
		res.rx_byte    = rx_done ? rx_q : 8'h00;
		res.rx_last    = rx_done & final_q;
		res.busy_res   = (phase_d != spi_mbe_pkg::PH_IDLE);
	end

	// Sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spi_mbe_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			final_q <= 1'b0;
			sck_q   <= 1'b0;
			sdo_q   <= 1'b0;
			cs_q    <= 1'b1;
		end else if (en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			final_q <= final_d;
			sck_q   <= sck_d;
			sdo_q   <= sdo_d;
			cs_q    <= cs_d;
		end
	end

endmodule
`default_nettype wire
